>>> src/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// Item and result types, request codes and character constants shared by the
// scrollback line ring.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int LINES = 64;
    localparam int COLS  = 64;

    localparam logic [2:0] REQ_CHAR  = 3'd0;
    localparam logic [2:0] REQ_BKSP  = 3'd1;
    localparam logic [2:0] REQ_WHEEL = 3'd2;
    localparam logic [2:0] REQ_HIST  = 3'd3;
    localparam logic [2:0] REQ_PART  = 3'd4;
    localparam logic [2:0] REQ_LIVE  = 3'd5;
    localparam logic [2:0] REQ_CLEAR = 3'd6;

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    localparam logic [7:0] VIS_RESET  = 8'd25;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [7:0]        char_code;
        logic signed [7:0] wheel_delta;
        logic [5:0]        line_index;
    } t_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic [6:0] line_count;
        logic [6:0] view_offset;
        logic [5:0] partial_length;
    } t_result;

endpackage

>>> src/tsb_scroll_clamp.sv
// ----------------------------------------------------------------------------
// tsb_scroll_clamp
// New view offset after a wheel step, clamped between zero and the scroll
// limit set by the line count, the visible rows and the partial line.
// ----------------------------------------------------------------------------
module tsb_scroll_clamp #(
    parameter int CW = 7
) (
    input  logic [CW-1:0]     i_count,
    input  logic [CW-1:0]     i_offset,
    input  logic [7:0]        i_visible,
    input  logic              i_has_partial,
    input  logic signed [7:0] i_delta,
    output logic [CW-1:0]     o_offset
);
    localparam int SW = CW + 10;

    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] off_s;
    logic signed [SW-1:0] vis_s;
    logic signed [SW-1:0] max_s;
    logic signed [SW-1:0] lim_s;
    logic signed [SW-1:0] nxt_s;

    always_comb begin
        cnt_s = $signed({{(SW-CW){1'b0}}, i_count});
        off_s = $signed({{(SW-CW){1'b0}}, i_offset});
        vis_s = $signed({{(SW-8){1'b0}}, i_visible});
        if (i_visible == 8'd0) begin
            vis_s = SW'(1);
        end
        max_s = cnt_s - vis_s;
        lim_s = max_s;
        if (i_has_partial && max_s > 0) begin
            lim_s = max_s + SW'(1);
        end
        if (lim_s < 0) begin
            lim_s = '0;
        end
        nxt_s = off_s + {{(SW-8){i_delta[7]}}, i_delta};
        if (nxt_s < 0) begin
            nxt_s = '0;
        end
        if (nxt_s > lim_s) begin
            nxt_s = lim_s;
        end
        o_offset = nxt_s[CW-1:0];
    end

endmodule

>>> src/text_scrollback_line_ring.sv
// ----------------------------------------------------------------------------
// text_scrollback_line_ring
// Ring of committed text lines plus one partial line, with scrolling and
// character readout of any held line.
// ----------------------------------------------------------------------------
// Characters are written straight into their row of the character memory,
// which holds LINES+1 rows so the partial line never shares a row with a held
// line; committing only stores the length and advances the row. Character,
// backspace, nonzero wheel, go-live and clear requests return their status
// item on the cycle after acceptance and can be accepted every cycle. A
// history read first looks up the line length in the length memory; a
// partial-line read skips that lookup. Then one character comes per cycle from
// the single read port of the character memory. busy is high while a readout is
// running. Results are strobed for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module text_scrollback_line_ring (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tsb_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    output logic             o_strobe,
    output tsb_pkg::t_result o_result
);
    import tsb_pkg::*;

    localparam int NROWS  = LINES + 1;
    localparam int CNT_W  = $clog2(LINES + 1);
    localparam int ROW_W  = $clog2(NROWS);
    localparam int LEN_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(NROWS * COLS);
    localparam int SW     = ((CNT_W > 6) ? CNT_W : 6) + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [7:0]       r_vis;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_off, n_off;
    logic [ROW_W-1:0] r_row, n_row;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [ROW_W-1:0] r_rd_row, n_rd_row;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_col, n_col;
    logic             r_strobe, n_strobe;
    t_result          r_res, n_res;

    logic [7:0]       mem_char [NROWS*COLS];
    logic [LEN_W-1:0] mem_len  [NROWS];
    logic [7:0]       r_rd_char;
    logic [LEN_W-1:0] r_rd_len;

    logic             char_we, char_re, len_we, len_re;
    logic [ROW_W-1:0] char_wrow, char_rrow, len_wrow, len_rrow;
    logic [LEN_W-1:0] char_wcol, char_rcol, len_wdata;
    logic [7:0]       char_wdata;
    logic [ADDR_W-1:0] char_waddr, char_raddr;

    logic             accept;
    logic [ROW_W-1:0] row_inc;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] wheel_off;
    logic [SW-1:0]    hist_sum;
    logic [ROW_W-1:0] hist_row;
    logic             hist_ok;
    logic             printable;

    tsb_scroll_clamp #(
        .CW(CNT_W)
    ) u_clamp (
        .i_count      (r_count),
        .i_offset     (r_off),
        .i_visible    (r_vis),
        .i_has_partial(r_plen != '0),
        .i_delta      (i_item.wheel_delta),
        .o_offset     (wheel_off)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        row_inc   = (r_row == ROW_W'(LINES)) ? '0 : r_row + ROW_W'(1);
        count_inc = (r_count < CNT_W'(LINES)) ? r_count + CNT_W'(1) : r_count;
        hist_ok   = SW'(i_item.line_index) < SW'(r_count);
        hist_sum  = SW'(r_row) + SW'(NROWS) - SW'(r_count) + SW'(i_item.line_index);
        if (hist_sum >= SW'(NROWS)) begin
            hist_sum = hist_sum - SW'(NROWS);
        end
        hist_row  = hist_sum[ROW_W-1:0];
        printable = (i_item.char_code >= CHAR_SPACE) && (i_item.char_code < CHAR_DEL);
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_off      = r_off;
        n_row      = r_row;
        n_plen     = r_plen;
        n_rd_row   = r_rd_row;
        n_len      = r_len;
        n_col      = r_col;
        n_strobe   = 1'b0;
        n_res      = '0;
        n_res.last = 1'b1;
        char_we    = 1'b0;
        char_wrow  = r_row;
        char_wcol  = r_plen;
        char_wdata = i_item.char_code;
        char_re    = 1'b0;
        char_rrow  = r_rd_row;
        char_rcol  = r_col;
        len_we     = 1'b0;
        len_wrow   = r_row;
        len_wdata  = r_plen;
        len_re     = 1'b0;
        len_rrow   = hist_row;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.req_type)
                        REQ_CHAR: begin
                            n_strobe = 1'b1;
                            if (i_item.char_code == CHAR_NL) begin
                                len_we  = 1'b1;
                                n_row   = row_inc;
                                n_count = count_inc;
                                n_plen  = '0;
                            end else if (printable) begin
                                char_we = 1'b1;
                                if (r_plen == LEN_W'(COLS - 1)) begin
                                    len_we    = 1'b1;
                                    n_row     = row_inc;
                                    n_count   = count_inc;
                                    char_wrow = row_inc;
                                    char_wcol = '0;
                                    n_plen    = LEN_W'(1);
                                end else begin
                                    n_plen = r_plen + LEN_W'(1);
                                end
                            end
                        end
                        REQ_BKSP: begin
                            n_strobe = 1'b1;
                            if (r_plen != '0) begin
                                n_plen = r_plen - LEN_W'(1);
                            end
                        end
                        REQ_WHEEL: begin
                            if (i_item.wheel_delta != 8'sd0) begin
                                n_strobe = 1'b1;
                                n_off    = wheel_off;
                            end
                        end
                        REQ_HIST: begin
                            if (hist_ok) begin
                                len_re   = 1'b1;
                                n_rd_row = hist_row;
                                n_state  = ST_LEN;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        REQ_PART: begin
                            if (r_plen == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                char_re   = 1'b1;
                                char_rrow = r_row;
                                char_rcol = '0;
                                n_rd_row  = r_row;
                                n_len     = r_plen;
                                n_col     = LEN_W'(1);
                                n_state   = ST_RUN;
                            end
                        end
                        REQ_LIVE: begin
                            n_strobe = 1'b1;
                            n_off    = '0;
                        end
                        REQ_CLEAR: begin
                            n_strobe = 1'b1;
                            n_plen   = '0;
                            n_count  = '0;
                            n_row    = '0;
                            n_off    = '0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if (r_rd_len == '0) begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    char_re   = 1'b1;
                    char_rrow = r_rd_row;
                    char_rcol = '0;
                    n_len     = r_rd_len;
                    n_col     = LEN_W'(1);
                    n_state   = ST_RUN;
                end
            end
            ST_RUN: begin
                n_strobe         = 1'b1;
                n_res.out_char   = r_rd_char;
                n_res.char_valid = 1'b1;
                n_res.last       = (r_col == r_len);
                if (r_col == r_len) begin
                    n_state = ST_IDLE;
                end else begin
                    char_re = 1'b1;
                    n_col   = r_col + LEN_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_res.line_count     = 7'(n_count);
        n_res.view_offset    = 7'(n_off);
        n_res.partial_length = 6'(n_plen);

        char_waddr = ADDR_W'(char_wrow) * ADDR_W'(COLS) + ADDR_W'(char_wcol);
        char_raddr = ADDR_W'(char_rrow) * ADDR_W'(COLS) + ADDR_W'(char_rcol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vis    <= VIS_RESET;
            r_count  <= '0;
            r_off    <= '0;
            r_row    <= '0;
            r_plen   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_off    <= n_off;
            r_row    <= n_row;
            r_plen   <= n_plen;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_vis <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= n_rd_row;
        r_len    <= n_len;
        r_col    <= n_col;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (char_we) begin
            mem_char[char_waddr] <= char_wdata;
        end
        if (char_re) begin
            r_rd_char <= mem_char[char_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            mem_len[len_wrow] <= len_wdata;
        end
        if (len_re) begin
            r_rd_len <= mem_len[len_rrow];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LINES))
        else $error("line count above ring depth");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= r_count)
        else $error("view offset beyond held lines");

    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.req_type != REQ_WHEEL && i_item.req_type != REQ_HIST
         && i_item.req_type != REQ_PART)
        |=> (o_strobe && o_result.last && !o_result.char_valid))
        else $error("status item missing after request");

    a_run_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |=> (o_strobe && o_result.char_valid))
        else $error("readout cycle gave no character item");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_scrollback_line_ring. A directed table covers
// the empty reads, the ignored bytes, the wheel clamps and clear; random runs
// of text lines, newline bursts, wheel steps and readouts follow under several
// visible_lines settings. Every strobed result is compared field by field
// against its table row or a behavioural copy of the line ring in the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsb_pkg::*;

    localparam int NROWS = LINES;
    localparam int NCOLS = COLS;
    localparam int LIMIT = 400000;
    localparam int TAIL  = 80;

    typedef struct {
        logic [2:0]        req;
        logic [7:0]        ch;
        logic signed [7:0] delta;
        logic [5:0]        lidx;
        bit                typed;
        logic [6:0]        lc;
        logic [6:0]        off;
        logic [5:0]        plen;
    } t_dir_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    logic       busy;
    t_item      i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic       o_strobe;
    t_result    o_result;

    text_scrollback_line_ring u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #2 i_clk = ~i_clk;

    // ring state as seen from outside
    logic [7:0] hist_chars [NROWS][NCOLS];
    int         hist_len   [NROWS];
    logic [7:0] part_chars [NCOLS];
    int         part_len  = 0;
    int         held      = 0;
    int         write_row = 0;
    int         offset    = 0;
    int         vis_rows  = VIS_RESET;

    t_result    due_results[$];
    t_result    step_out[$];
    t_dir_row   dir_rows[$];
    t_result    want_res;

    int errors     = 0;
    int checked    = 0;
    int sent       = 0;
    int chars_read = 0;
    int wraps      = 0;
    int cycles     = 0;

    task automatic report(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("result %0d %s got %0d want %0d", checked, name, got, want));
        end
    endtask

    function automatic t_result line_result(input logic [7:0] ch, input logic valid,
                                            input logic fin);
        t_result r;
        r.out_char       = ch;
        r.char_valid     = valid;
        r.last           = fin;
        r.line_count     = 7'(held);
        r.view_offset    = 7'(offset);
        r.partial_length = 6'(part_len);
        return r;
    endfunction

    task automatic emit_run(input bit from_hist, input int row, input int len);
        logic [7:0] c;
        if (len == 0) begin
            step_out.push_back(line_result(8'd0, 1'b0, 1'b1));
            return;
        end
        for (int i = 0; i < len; i++) begin
            c = from_hist ? hist_chars[row][i] : part_chars[i];
            step_out.push_back(line_result(c, 1'b1, i == len - 1));
            chars_read++;
        end
    endtask

    task automatic commit_partial();
        for (int i = 0; i < part_len; i++) begin
            hist_chars[write_row][i] = part_chars[i];
        end
        hist_len[write_row] = part_len;
        write_row = (write_row + 1) % NROWS;
        if (held < NROWS) begin
            held++;
        end else begin
            wraps++;
        end
        part_len = 0;
    endtask

    task automatic feed_byte(input logic [7:0] ch);
        if (ch == CHAR_NL) begin
            commit_partial();
        end else if (ch >= CHAR_SPACE && ch < CHAR_DEL) begin
            if (part_len + 1 >= NCOLS) begin
                commit_partial();
            end
            part_chars[part_len] = ch;
            part_len++;
        end
    endtask

    task automatic turn_wheel(input int delta);
        int vis;
        int max_off;
        int nxt;
        vis = (vis_rows < 1) ? 1 : vis_rows;
        max_off = held - vis;
        if (part_len > 0 && max_off > 0) begin
            max_off = held - vis + 1;
        end
        if (max_off < 0) begin
            max_off = 0;
        end
        nxt = offset + delta;
        if (nxt < 0) begin
            nxt = 0;
        end
        if (nxt > max_off) begin
            nxt = max_off;
        end
        offset = nxt;
    endtask

    // work out the results of one accepted item into step_out
    task automatic apply_request(input t_item it);
        int row;
        step_out.delete();
        case (it.req_type)
            REQ_CHAR: feed_byte(it.char_code);
            REQ_BKSP: begin
                if (part_len > 0) begin
                    part_len--;
                end
            end
            REQ_WHEEL: begin
                if (it.wheel_delta == 0) begin
                    return;
                end
                turn_wheel(int'($signed(it.wheel_delta)));
            end
            REQ_HIST: begin
                if (int'(it.line_index) < held) begin
                    row = (write_row + NROWS - held + int'(it.line_index)) % NROWS;
                    emit_run(1'b1, row, hist_len[row]);
                end else begin
                    emit_run(1'b0, 0, 0);
                end
                return;
            end
            REQ_PART: begin
                emit_run(1'b0, 0, part_len);
                return;
            end
            REQ_LIVE: offset = 0;
            REQ_CLEAR: begin
                part_len  = 0;
                held      = 0;
                write_row = 0;
                offset    = 0;
            end
            default: ;
        endcase
        step_out.push_back(line_result(8'd0, 1'b0, 1'b1));
    endtask

    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        apply_request(it);
        if (typed) begin
            due_results.push_back(typed_res);
        end else begin
            foreach (step_out[k]) begin
                due_results.push_back(step_out[k]);
            end
        end
        sent++;
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        vis_rows = v;
    endtask

    function automatic t_item noise_item();
        t_item it;
        it.req_type    = 3'($urandom_range(0, 7));
        it.char_code   = 8'($urandom);
        it.wheel_delta = 8'($urandom);
        it.line_index  = 6'($urandom);
        return it;
    endfunction

    function automatic bit ignored(input t_item it);
        if (it.req_type == REQ_CHAR && it.char_code != CHAR_NL &&
            (it.char_code < CHAR_SPACE || it.char_code >= CHAR_DEL)) begin
            return 1'b1;
        end
        return it.req_type == REQ_WHEEL && it.wheel_delta == 0;
    endfunction

    task automatic issue(input t_item it, input bit gaps, inout int n);
        if (gaps && $urandom_range(0, 9) == 0) begin
            hold_off($urandom_range(1, 11));
        end
        send_item(it, 1'b0, '0);
        if (!ignored(it)) begin
            n++;
        end
    endtask

    task automatic run_phase(input int quota, input bit gaps);
        int    n;
        int    kind;
        int    len;
        t_item it;
        n = 0;
        while (n < quota) begin
            kind = $urandom_range(0, 99);
            it = noise_item();
            if (kind < 38) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(0, 8);
                for (int k = 0; k < len; k++) begin
                    it = noise_item();
                    it.req_type  = ($urandom_range(0, 11) == 0) ? REQ_BKSP : REQ_CHAR;
                    it.char_code = 8'($urandom_range(32, 126));
                    issue(it, gaps, n);
                end
                if ($urandom_range(0, 3) != 0) begin
                    it = noise_item();
                    it.req_type  = REQ_CHAR;
                    it.char_code = CHAR_NL;
                    issue(it, gaps, n);
                end
            end else if (kind < 50) begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++) begin
                    it = noise_item();
                    it.req_type  = REQ_CHAR;
                    it.char_code = CHAR_NL;
                    issue(it, gaps, n);
                end
            end else if (kind < 62) begin
                it.req_type = REQ_WHEEL;
                len = $urandom_range(0, 7);
                if (len == 0) begin
                    it.wheel_delta = '0;
                end else if (len < 4) begin
                    it.wheel_delta = 8'($urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 0) begin
                        it.wheel_delta = -it.wheel_delta;
                    end
                end
                issue(it, gaps, n);
            end else if (kind < 76) begin
                it.req_type = REQ_HIST;
                if (held > 0 && $urandom_range(0, 4) != 0) begin
                    it.line_index = 6'($urandom_range(0, held - 1));
                end
                issue(it, gaps, n);
            end else if (kind < 84) begin
                it.req_type = REQ_PART;
                issue(it, gaps, n);
            end else if (kind < 89) begin
                it.req_type = REQ_LIVE;
                issue(it, gaps, n);
            end else if (kind < 90) begin
                it.req_type = REQ_CLEAR;
                issue(it, gaps, n);
            end else begin
                issue(it, gaps, n);
            end
        end
    endtask

    task automatic add_row(input logic [2:0] req, input logic [7:0] ch,
                           input logic signed [7:0] delta, input logic [5:0] lidx,
                           input bit typed, input logic [6:0] lc,
                           input logic [6:0] off, input logic [5:0] plen);
        t_dir_row r;
        r.req   = req;
        r.ch    = ch;
        r.delta = delta;
        r.lidx  = lidx;
        r.typed = typed;
        r.lc    = lc;
        r.off   = off;
        r.plen  = plen;
        dir_rows.push_back(r);
    endtask

    task automatic load_directed();
        add_row(REQ_PART,  8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd0);
        add_row(REQ_HIST,  8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd0);
        add_row(REQ_WHEEL, 8'd0,   8'sd5,   6'd0,  1, 7'd0, 7'd0, 6'd0);
        add_row(REQ_WHEEL, 8'd0,   8'sd0,   6'd0,  0, 7'd0, 7'd0, 6'd0);
        add_row(REQ_BKSP,  8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd0);
        add_row(REQ_CHAR,  8'd65,  8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd1);
        add_row(REQ_CHAR,  CHAR_SPACE, 8'sd0, 6'd0, 1, 7'd0, 7'd0, 6'd2);
        add_row(REQ_CHAR,  8'd126, 8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd3);
        add_row(REQ_CHAR,  8'd31,  8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd3);
        add_row(REQ_CHAR,  CHAR_DEL, 8'sd0, 6'd0,  1, 7'd0, 7'd0, 6'd3);
        add_row(REQ_CHAR,  8'd128, 8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd3);
        add_row(REQ_CHAR,  8'd255, 8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd3);
        add_row(REQ_CHAR,  8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd3);
        add_row(REQ_PART,  8'd0,   8'sd0,   6'd0,  0, 7'd0, 7'd0, 6'd0);
        add_row(REQ_BKSP,  8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd2);
        add_row(REQ_CHAR,  CHAR_NL, 8'sd0,  6'd0,  1, 7'd1, 7'd0, 6'd0);
        add_row(REQ_HIST,  8'd0,   8'sd0,   6'd0,  0, 7'd0, 7'd0, 6'd0);
        add_row(REQ_HIST,  8'd0,   8'sd0,   6'd63, 1, 7'd1, 7'd0, 6'd0);
        add_row(REQ_CHAR,  CHAR_NL, 8'sd0,  6'd0,  1, 7'd2, 7'd0, 6'd0);
        add_row(REQ_HIST,  8'd0,   8'sd0,   6'd1,  1, 7'd2, 7'd0, 6'd0);
        add_row(3'd7,      8'd0,   8'sd0,   6'd0,  1, 7'd2, 7'd0, 6'd0);
        add_row(REQ_WHEEL, 8'd0,   8'sh80,  6'd0,  1, 7'd2, 7'd0, 6'd0);
        add_row(REQ_WHEEL, 8'd0,   8'sd127, 6'd0,  1, 7'd2, 7'd0, 6'd0);
        add_row(REQ_LIVE,  8'd0,   8'sd0,   6'd0,  1, 7'd2, 7'd0, 6'd0);
        add_row(REQ_CLEAR, 8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd0);
        add_row(REQ_HIST,  8'd0,   8'sd0,   6'd0,  1, 7'd0, 7'd0, 6'd0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                report($sformatf("result with nothing pending: %h", o_result));
            end else begin
                want_res = due_results.pop_front();
                check_field("out_char", o_result.out_char, want_res.out_char);
                check_field("char_valid", 8'(o_result.char_valid), 8'(want_res.char_valid));
                check_field("last", 8'(o_result.last), 8'(want_res.last));
                check_field("line_count", 8'(o_result.line_count), 8'(want_res.line_count));
                check_field("view_offset", 8'(o_result.view_offset),
                            8'(want_res.view_offset));
                check_field("partial_length", 8'(o_result.partial_length),
                            8'(want_res.partial_length));
                checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("** text_scrollback_line_ring: FAILED **");
            $finish;
        end
    end

    initial begin
        t_item   it;
        t_result tr;
        int      vis_mid;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_directed();
        foreach (dir_rows[r]) begin
            it.req_type       = dir_rows[r].req;
            it.char_code      = dir_rows[r].ch;
            it.wheel_delta    = dir_rows[r].delta;
            it.line_index     = dir_rows[r].lidx;
            tr.out_char       = 8'd0;
            tr.char_valid     = 1'b0;
            tr.last           = 1'b1;
            tr.line_count     = dir_rows[r].lc;
            tr.view_offset    = dir_rows[r].off;
            tr.partial_length = dir_rows[r].plen;
            send_item(it, dir_rows[r].typed, tr);
        end

        drain();
        write_cfg(8'd1);
        // overfill the ring so it wraps
        for (int k = 0; k < NROWS + 2; k++) begin
            it = noise_item();
            it.req_type  = REQ_CHAR;
            it.char_code = CHAR_NL;
            send_item(it, 1'b0, '0);
        end
        run_phase(25, 1'b1);

        drain();
        write_cfg(8'd255);
        run_phase(20, 1'b1);

        drain();
        write_cfg(8'd0);
        run_phase(20, 1'b1);

        drain();
        vis_mid = $urandom_range(2, 254);
        write_cfg(8'(vis_mid));
        run_phase(20, 1'b1);

        drain();
        write_cfg(8'd3);
        run_phase(30, 1'b0);

        drain();
        repeat (TAIL) @(posedge i_clk);
        if (due_results.size() != 0) begin
            report($sformatf("%0d results never arrived", due_results.size()));
        end

        $display("Sent %0d requests over visible_lines 25, 1, 255, 0, %0d and 3;",
                 sent, vis_mid);
        $display("checked %0d results, %0d characters read back, ring wrapped %0d times.",
                 checked, chars_read, wraps);
        if (errors == 0) begin
            $display("** text_scrollback_line_ring: PASSED **");
        end else begin
            $display("** text_scrollback_line_ring: FAILED **");
        end
        $finish;
    end

endmodule
